// ----- hw/rtl/pfrj_pkg.sv -----
// Package for the point feature residual and Jacobian pipeline: types, constants, arithmetic.
`default_nettype none
package pfrj_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int CW = COORD_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int RB = FB + 2;
	localparam int ROWW = 3 * RB;
	localparam int XW = CW + 6;
	localparam int SQRT_STEPS = (CW + FB + 1) / 2;
	localparam int RW = SQRT_STEPS + 2;
	localparam int SQ_PER = 4;
	localparam int SQ_STAGES = (SQRT_STEPS + SQ_PER - 1) / SQ_PER;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W = (ROWW > CW) ? ROWW : CW;
	localparam int IN_W = ((10 * CW - 1 + 7) / 8) * 8;
	localparam int OUT_W = ((7 * CW + 7) / 8) * 8;

	typedef logic signed [CW-1:0] q_t;
	typedef logic signed [XW-1:0] w_t;

	typedef struct packed {
		q_t v;
		logic s;
	} qs_t;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [RW-1:0] root;
	} sq_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT0 = 3'd0,
		REG_ROT1 = 3'd1,
		REG_ROT2 = 3'd2,
		REG_TX   = 3'd3,
		REG_TY   = 3'd4,
		REG_TZ   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][ROWW-1:0] rot;
		logic [2:0][CW-1:0] trans;
	} cfg_t;

	typedef struct packed {
		logic mode;
		logic [2:0][CW-1:0] p;
		logic [2:0][CW-1:0] a;
		logic [2:0][CW-1:0] b;
		logic [CW-2:0] w;
	} in_t;

	typedef struct packed {
		logic mode;
		logic [CW-2:0] w;
		logic [2:0][CW-1:0] v;
		logic [2:0][CW-1:0] e;
		logic [CW-1:0] res;
		logic [2:0][CW-1:0] jr;
		logic [2:0][CW-1:0] jp;
		logic sat;
	} pl_t;

	typedef struct packed {
		logic [CW-1:0] res;
		logic [2:0][CW-1:0] jr;
		logic [2:0][CW-1:0] jp;
		logic sat;
	} rs_t;

	localparam q_t MAXQ = {1'b0, {(CW-1){1'b1}}};
	localparam q_t MINQ = {1'b1, {(CW-1){1'b0}}};
	localparam w_t WMAX = w_t'(MAXQ);
	localparam w_t WMIN = w_t'(MINQ);
	localparam logic [2*CW-1:0] QHALF = (2*CW)'(1) << (FB - 1);
	localparam logic [2*CW-1:0] LIMP = (2*CW)'(MAXQ);
	localparam logic [2*CW-1:0] LIMN = LIMP + (2*CW)'(1);
	localparam logic [ROWW-1:0] ROT_ID0 = ROWW'(1) << FB;
	localparam logic [ROWW-1:0] ROT_ID1 = ROWW'(1) << (FB + RB);
	localparam logic [ROWW-1:0] ROT_ID2 = ROWW'(1) << (FB + 2 * RB);
	localparam w_t EDGE_GAIN = w_t'(5);
	localparam w_t FOOT_GAIN = w_t'(25);

	function automatic int nx1(int i);
		return (i == 2) ? 0 : i + 1;
	endfunction

	function automatic int nx2(int i);
		return (i == 0) ? 2 : i - 1;
	endfunction

	function automatic w_t wx(q_t a);
		return w_t'(a);
	endfunction

	// Product rounded half away from zero, then clipped to the coordinate range.
	function automatic qs_t qmul(q_t a, q_t b);
		logic signed [2*CW-1:0] p;
		logic [2*CW-1:0] mg;
		logic [2*CW-1:0] r;
		logic [2*CW-1:0] lim;
		logic neg;
		qs_t y;
		p = a * b;
		neg = p[2*CW-1];
		mg = neg ? -p : p;
		r = (mg + QHALF) >> FB;
		lim = neg ? LIMN : LIMP;
		if (r > lim) begin
			y.s = 1'b1;
			y.v = neg ? MINQ : MAXQ;
		end else begin
			y.s = 1'b0;
			y.v = neg ? -q_t'(r[CW-1:0]) : q_t'(r[CW-1:0]);
		end
		return y;
	endfunction

	function automatic qs_t clipw(w_t x);
		qs_t y;
		if (x > WMAX) begin
			y.s = 1'b1;
			y.v = MAXQ;
		end else if (x < WMIN) begin
			y.s = 1'b1;
			y.v = MINQ;
		end else begin
			y.s = 1'b0;
			y.v = q_t'(x[CW-1:0]);
		end
		return y;
	endfunction

	function automatic q_t rot_el(logic [ROWW-1:0] row, int j);
		logic signed [RB-1:0] e;
		e = row[j*RB +: RB];
		return q_t'(e);
	endfunction

	// One restoring square root digit; the operand carries FB implied zero bits below it.
	function automatic sq_t sq_step(sq_t x, logic [CW+1:0] us, int i);
		int k;
		logic hi;
		logic lo;
		logic [RW-1:0] r2;
		logic [RW-1:0] trial;
		sq_t y;
		k = 2 * i;
		hi = 1'b0;
		lo = 1'b0;
		if (k + 1 >= FB) begin
			hi = us[k+1-FB];
		end
		if (k >= FB) begin
			lo = us[k-FB];
		end
		r2 = {x.rem[RW-3:0], hi, lo};
		trial = {x.root[RW-3:0], 2'b01};
		if (r2 >= trial) begin
			y.rem = r2 - trial;
			y.root = {x.root[RW-2:0], 1'b1};
		end else begin
			y.rem = r2;
			y.root = {x.root[RW-2:0], 1'b0};
		end
		return y;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/point_feature_residual_jacobian_top.sv -----
// Top level of the point feature residual and Jacobian pipeline.
`default_nettype none
// Each request is one scan point with its matched plane or line, and each gives exactly one
// result. A new request is taken in every cycle while the result side takes results. The
// pipeline has seven stages for the pose transform and the geometry, six stages
// of the square root at four digits per stage, and three stages for the final scaling, the
// last of which is the output register. When a result waits the whole pipeline holds, so
// s_tready follows m_tready. The pose is written through the cfg channel, which is always
// ready; the user must write it only while no request is in flight, which the block does not enforce.
module point_feature_residual_jacobian_top import pfrj_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// pt_x, pt_y, pt_z, geo_a_x, geo_a_y, geo_a_z, geo_b_x, geo_b_y, geo_b_z, weight, pad
	input  logic [IN_W-1:0]      s_tdata,
	// mode
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// residual, jac_rot_x, jac_rot_y, jac_rot_z, jac_pos_x, jac_pos_y, jac_pos_z
	output logic [OUT_W-1:0]     m_tdata,
	// saturated
	output logic                 m_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t cfg;
	in_t item;
	logic en;
	logic g_valid;
	q_t g_sq;
	pl_t g_pl;
	logic r_valid;
	logic [RW-1:0] r_root;
	pl_t r_pl;
	rs_t rs;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		item.mode = s_tuser;
		for (int i = 0; i < 3; i++) begin
			item.p[i] = s_tdata[i*CW +: CW];
			item.a[i] = s_tdata[(3+i)*CW +: CW];
			item.b[i] = s_tdata[(6+i)*CW +: CW];
		end
		item.w = s_tdata[9*CW +: CW-1];
	end

	pfrj_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_ready (cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	pfrj_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.item      (item),
		.cfg       (cfg),
		.out_valid (g_valid),
		.out_sq    (g_sq),
		.out_pl    (g_pl)
	);

	pfrj_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (g_valid),
		.sq_in     (g_sq),
		.pl_in     (g_pl),
		.out_valid (r_valid),
		.root      (r_root),
		.out_pl    (r_pl)
	);

	pfrj_tail u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r_valid),
		.root      (r_root),
		.pl_in     (r_pl),
		.out_valid (m_tvalid),
		.out_rs    (rs)
	);

	always_comb begin
		m_tdata = '0;
		m_tdata[0 +: CW] = rs.res;
		for (int i = 0; i < 3; i++) begin
			m_tdata[(1+i)*CW +: CW] = rs.jr[i];
			m_tdata[(4+i)*CW +: CW] = rs.jp[i];
		end
	end

	assign m_tuser = rs.sat;

endmodule
`default_nettype wire

// ----- hw/rtl/pfrj_cfg.sv -----
// Pose register file written through the configuration channel.
`default_nettype none
module pfrj_cfg import pfrj_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot[0] <= ROT_ID0;
			cfg_q.rot[1] <= ROT_ID1;
			cfg_q.rot[2] <= ROT_ID2;
			cfg_q.trans <= '0;
		end else if (wr_valid) begin
			case (reg_idx_t'(wr_index))
				REG_ROT0: cfg_q.rot[0] <= wr_data[ROWW-1:0];
				REG_ROT1: cfg_q.rot[1] <= wr_data[ROWW-1:0];
				REG_ROT2: cfg_q.rot[2] <= wr_data[ROWW-1:0];
				REG_TX:   cfg_q.trans[0] <= wr_data[CW-1:0];
				REG_TY:   cfg_q.trans[1] <= wr_data[CW-1:0];
				REG_TZ:   cfg_q.trans[2] <= wr_data[CW-1:0];
				default:  ;
			endcase
		end
	end

	a_tx_written: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_valid && wr_index == REG_TX) |=> cfg_q.trans[0] == $past(wr_data[CW-1:0]))
		else $error("translation x not taken from the write request");

	a_bad_index: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_valid && wr_index > REG_TZ) |=> $stable(cfg_q))
		else $error("write to an unknown register changed the pose");

endmodule
`default_nettype wire

// ----- hw/rtl/pfrj_geom.sv -----
// Front pipeline: pose transform, plane results, line cross products, foot point and squared norm.
`default_nettype none
module pfrj_geom import pfrj_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  in_t  item,
	input  cfg_t cfg,
	output logic out_valid,
	output q_t   out_sq,
	output pl_t  out_pl
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	in_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6;
	q_t pr_s1 [9];
	logic satc_s1, satc_s2, satc_s3, satc_s4, satc_s5, satc_s6;
	logic satp_s3, satp_s4, satp_s5, satp_s6;
	logic satl_s3, satl_s4, satl_s5, satl_s6;
	q_t v_s2 [3], v_s3 [3], v_s4 [3], v_s5 [3], v_s6 [3];
	q_t m_s2 [3], m_s3 [3], m_s4 [3], m_s5 [3], m_s6 [3];
	q_t dp_s3 [3], cp_s3 [6], am_s3 [3], bm_s3 [3], ab_s3 [3];
	q_t ab_s4 [3], rp_s4, cpl_s4 [3], xp_s4 [6], kp_s4 [3];
	q_t ab_s5 [3], resp_s5, jrp_s5 [3], jpp_s5 [3], cl_s5 [3], kk_s5;
	q_t resp_s6, jrp_s6 [3], jpp_s6 [3], ss_s6 [3], fp_s6 [3];
	q_t sq_s7;
	pl_t pl_s7;

	qs_t n1_pr [9];
	logic n1_sat;
	qs_t n2_v [3], n2_m [3];
	logic n2_sat;
	qs_t n3_dp [3], n3_cp [6], n3_am [3], n3_bm [3], n3_ab [3];
	logic n3_satp, n3_satl;
	qs_t n4_dot, n4_rp, n4_cpl [3], n4_xp [6], n4_kp [3];
	logic n4_satp, n4_satl;
	qs_t n5_res, n5_jr [3], n5_jp [3], n5_cl [3], n5_kd, n5_kk;
	q_t n5_w;
	logic n5_satp, n5_satl;
	qs_t n6_ss [3], n6_fp [3];
	logic n6_satl;
	qs_t n7_s, n7_f [3], n7_e [3];
	logic n7_satl;
	pl_t n7_pl;

	always_comb begin
		n1_sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				n1_pr[i*3+j] = qmul(rot_el(cfg.rot[i], j), $signed(item.p[j]));
				n1_sat = n1_sat | n1_pr[i*3+j].s;
			end
		end
	end

	always_comb begin
		n2_sat = satc_s1;
		for (int i = 0; i < 3; i++) begin
			n2_v[i] = clipw(wx(pr_s1[3*i]) + wx(pr_s1[3*i+1]) + wx(pr_s1[3*i+2]));
			n2_m[i] = clipw(wx(n2_v[i].v) + wx($signed(cfg.trans[i])));
			n2_sat = n2_sat | n2_v[i].s | n2_m[i].s;
		end
	end

	always_comb begin
		n3_satp = 1'b0;
		n3_satl = 1'b0;
		for (int i = 0; i < 3; i++) begin
			n3_dp[i] = qmul($signed(it_s2.a[i]), m_s2[i]);
			n3_cp[2*i] = qmul(v_s2[nx1(i)], $signed(it_s2.a[nx2(i)]));
			n3_cp[2*i+1] = qmul(v_s2[nx2(i)], $signed(it_s2.a[nx1(i)]));
			n3_am[i] = clipw(wx(m_s2[i]) - wx($signed(it_s2.a[i])));
			n3_bm[i] = clipw(wx(m_s2[i]) - wx($signed(it_s2.b[i])));
			n3_ab[i] = clipw(wx($signed(it_s2.b[i])) - wx($signed(it_s2.a[i])));
			n3_satp = n3_satp | n3_dp[i].s | n3_cp[2*i].s | n3_cp[2*i+1].s;
			n3_satl = n3_satl | n3_am[i].s | n3_bm[i].s | n3_ab[i].s;
		end
	end

	always_comb begin
		n4_dot = clipw(wx(dp_s3[0]) + wx(dp_s3[1]) + wx(dp_s3[2]));
		n4_rp = clipw(wx(n4_dot.v) + wx($signed(it_s3.b[0])));
		n4_satp = satp_s3 | n4_dot.s | n4_rp.s;
		n4_satl = satl_s3;
		for (int i = 0; i < 3; i++) begin
			n4_cpl[i] = clipw(wx(cp_s3[2*i]) - wx(cp_s3[2*i+1]));
			n4_xp[2*i] = qmul(am_s3[nx1(i)], bm_s3[nx2(i)]);
			n4_xp[2*i+1] = qmul(am_s3[nx2(i)], bm_s3[nx1(i)]);
			n4_kp[i] = qmul(ab_s3[i], am_s3[i]);
			n4_satp = n4_satp | n4_cpl[i].s;
			n4_satl = n4_satl | n4_xp[2*i].s | n4_xp[2*i+1].s | n4_kp[i].s;
		end
	end

	always_comb begin
		n5_w = q_t'({1'b0, it_s4.w});
		n5_res = qmul(n5_w, rp_s4);
		n5_kd = clipw(wx(kp_s4[0]) + wx(kp_s4[1]) + wx(kp_s4[2]));
		n5_kk = clipw(wx(n5_kd.v) * FOOT_GAIN);
		n5_satp = satp_s4 | n5_res.s;
		n5_satl = satl_s4 | n5_kd.s | n5_kk.s;
		for (int i = 0; i < 3; i++) begin
			n5_jr[i] = qmul(n5_w, cpl_s4[i]);
			n5_jp[i] = qmul(n5_w, $signed(it_s4.a[i]));
			n5_cl[i] = clipw(wx(xp_s4[2*i]) - wx(xp_s4[2*i+1]));
			n5_satp = n5_satp | n5_jr[i].s | n5_jp[i].s;
			n5_satl = n5_satl | n5_cl[i].s;
		end
	end

	always_comb begin
		n6_satl = satl_s5;
		for (int i = 0; i < 3; i++) begin
			n6_ss[i] = qmul(cl_s5[i], cl_s5[i]);
			n6_fp[i] = qmul(kk_s5, ab_s5[i]);
			n6_satl = n6_satl | n6_ss[i].s | n6_fp[i].s;
		end
	end

	always_comb begin
		n7_s = clipw(wx(ss_s6[0]) + wx(ss_s6[1]) + wx(ss_s6[2]));
		n7_satl = satl_s6 | n7_s.s;
		for (int i = 0; i < 3; i++) begin
			n7_f[i] = clipw(wx($signed(it_s6.a[i])) + wx(fp_s6[i]));
			n7_e[i] = clipw(wx(m_s6[i]) - wx(n7_f[i].v));
			n7_satl = n7_satl | n7_f[i].s | n7_e[i].s;
		end
		n7_pl.mode = it_s6.mode;
		n7_pl.w = it_s6.w;
		n7_pl.res = resp_s6;
		for (int i = 0; i < 3; i++) begin
			n7_pl.v[i] = v_s6[i];
			n7_pl.e[i] = n7_e[i].v;
			n7_pl.jr[i] = jrp_s6[i];
			n7_pl.jp[i] = jpp_s6[i];
		end
		n7_pl.sat = satc_s6 | (it_s6.mode ? n7_satl : satp_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= item;
			satc_s1 <= n1_sat;
			for (int i = 0; i < 9; i++) begin
				pr_s1[i] <= n1_pr[i].v;
			end
			it_s2 <= it_s1;
			satc_s2 <= n2_sat;
			it_s3 <= it_s2;
			satc_s3 <= satc_s2;
			satp_s3 <= n3_satp;
			satl_s3 <= n3_satl;
			it_s4 <= it_s3;
			satc_s4 <= satc_s3;
			satp_s4 <= n4_satp;
			satl_s4 <= n4_satl;
			rp_s4 <= n4_rp.v;
			it_s5 <= it_s4;
			satc_s5 <= satc_s4;
			satp_s5 <= n5_satp;
			satl_s5 <= n5_satl;
			resp_s5 <= n5_res.v;
			kk_s5 <= n5_kk.v;
			it_s6 <= it_s5;
			satc_s6 <= satc_s5;
			satp_s6 <= satp_s5;
			satl_s6 <= n6_satl;
			resp_s6 <= resp_s5;
			sq_s7 <= n7_s.v;
			pl_s7 <= n7_pl;
			for (int i = 0; i < 3; i++) begin
				v_s2[i] <= n2_v[i].v;
				m_s2[i] <= n2_m[i].v;
				v_s3[i] <= v_s2[i];
				m_s3[i] <= m_s2[i];
				dp_s3[i] <= n3_dp[i].v;
				am_s3[i] <= n3_am[i].v;
				bm_s3[i] <= n3_bm[i].v;
				ab_s3[i] <= n3_ab[i].v;
				v_s4[i] <= v_s3[i];
				m_s4[i] <= m_s3[i];
				ab_s4[i] <= ab_s3[i];
				cpl_s4[i] <= n4_cpl[i].v;
				kp_s4[i] <= n4_kp[i].v;
				v_s5[i] <= v_s4[i];
				m_s5[i] <= m_s4[i];
				ab_s5[i] <= ab_s4[i];
				jrp_s5[i] <= n5_jr[i].v;
				jpp_s5[i] <= n5_jp[i].v;
				cl_s5[i] <= n5_cl[i].v;
				v_s6[i] <= v_s5[i];
				m_s6[i] <= m_s5[i];
				jrp_s6[i] <= jrp_s5[i];
				jpp_s6[i] <= jpp_s5[i];
				ss_s6[i] <= n6_ss[i].v;
				fp_s6[i] <= n6_fp[i].v;
			end
			for (int i = 0; i < 6; i++) begin
				cp_s3[i] <= n3_cp[i].v;
				xp_s4[i] <= n4_xp[i].v;
			end
		end
	end

	assign out_valid = vld_s7;
	assign out_sq = sq_s7;
	assign out_pl = pl_s7;

endmodule
`default_nettype wire

// ----- hw/rtl/pfrj_sqrt.sv -----
// Pipelined restoring square root, four digits per stage, with the item carried alongside.
`default_nettype none
module pfrj_sqrt import pfrj_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  q_t            sq_in,
	input  pl_t           pl_in,
	output logic          out_valid,
	output logic [RW-1:0] root,
	output pl_t           out_pl
);

	logic vld_s [SQ_STAGES];
	sq_t sq_s [SQ_STAGES];
	logic [CW+1:0] us_s [SQ_STAGES];
	pl_t pl_s [SQ_STAGES];

	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
		sq_t src;
		sq_t nxt;
		logic [CW+1:0] usrc;
		pl_t psrc;
		logic vsrc;

		if (g == 0) begin : g_first
			assign src = '0;
			assign usrc = {2'b00, sq_in};
			assign psrc = pl_in;
			assign vsrc = in_valid;
		end else begin : g_next
			assign src = sq_s[g-1];
			assign usrc = us_s[g-1];
			assign psrc = pl_s[g-1];
			assign vsrc = vld_s[g-1];
		end

		always_comb begin
			nxt = src;
			for (int j = 0; j < SQ_PER; j++) begin
				if (SQRT_STEPS - 1 - g * SQ_PER - j >= 0) begin
					nxt = sq_step(nxt, usrc, SQRT_STEPS - 1 - g * SQ_PER - j);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vsrc;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[g] <= nxt;
				us_s[g] <= usrc;
				pl_s[g] <= psrc;
			end
		end
	end

	assign out_valid = vld_s[SQ_STAGES-1];
	assign root = sq_s[SQ_STAGES-1].root;
	assign out_pl = pl_s[SQ_STAGES-1];

	a_root_width: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[SQ_STAGES-1] |-> sq_s[SQ_STAGES-1].root[RW-1:SQRT_STEPS] == '0)
		else $error("square root wider than its digit count");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[SQ_STAGES-1] |->
			sq_s[SQ_STAGES-1].rem <= {sq_s[SQ_STAGES-1].root[RW-2:0], 1'b0})
		else $error("square root remainder exceeds twice the root");

endmodule
`default_nettype wire

// ----- hw/rtl/pfrj_tail.sv -----
// Back pipeline: line residual scaling, line Jacobians and the output register.
`default_nettype none
module pfrj_tail import pfrj_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [RW-1:0] root,
	input  pl_t           pl_in,
	output logic          out_valid,
	output rs_t           out_rs
);

	logic vld_s1, vld_s2, vld_s3;
	pl_t pl_s1, pl_s2;
	q_t r5_s1, ve_s1 [6], je_s1 [3], je_s2 [3], rw_s2, cr_s2 [3];
	logic satl_s1, satl_s2;
	rs_t rs_s3;

	q_t n1_w, n2_w, n3_w;
	qs_t n1_r5, n1_ve [6], n1_je [3];
	logic n1_sat;
	qs_t n2_rw, n2_cr [3];
	logic n2_sat;
	qs_t n3_jr [3];
	logic n3_sat;
	rs_t n3_rs;

	always_comb begin
		n1_w = q_t'({1'b0, pl_in.w});
		n1_r5 = clipw(w_t'($signed({1'b0, root})) * EDGE_GAIN);
		n1_sat = n1_r5.s;
		for (int i = 0; i < 3; i++) begin
			n1_ve[2*i] = qmul($signed(pl_in.v[nx1(i)]), $signed(pl_in.e[nx2(i)]));
			n1_ve[2*i+1] = qmul($signed(pl_in.v[nx2(i)]), $signed(pl_in.e[nx1(i)]));
			n1_je[i] = qmul(n1_w, $signed(pl_in.e[i]));
			n1_sat = n1_sat | n1_ve[2*i].s | n1_ve[2*i+1].s | n1_je[i].s;
		end
	end

	always_comb begin
		n2_w = q_t'({1'b0, pl_s1.w});
		n2_rw = qmul(n2_w, r5_s1);
		n2_sat = satl_s1 | n2_rw.s;
		for (int i = 0; i < 3; i++) begin
			n2_cr[i] = clipw(wx(ve_s1[2*i]) - wx(ve_s1[2*i+1]));
			n2_sat = n2_sat | n2_cr[i].s;
		end
	end

	always_comb begin
		n3_w = q_t'({1'b0, pl_s2.w});
		n3_sat = satl_s2;
		for (int i = 0; i < 3; i++) begin
			n3_jr[i] = qmul(n3_w, cr_s2[i]);
			n3_sat = n3_sat | n3_jr[i].s;
		end
		if (pl_s2.mode) begin
			n3_rs.res = rw_s2;
			for (int i = 0; i < 3; i++) begin
				n3_rs.jr[i] = n3_jr[i].v;
				n3_rs.jp[i] = je_s2[i];
			end
			n3_rs.sat = pl_s2.sat | n3_sat;
		end else begin
			n3_rs.res = pl_s2.res;
			n3_rs.jr = pl_s2.jr;
			n3_rs.jp = pl_s2.jp;
			n3_rs.sat = pl_s2.sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= pl_in;
			r5_s1 <= n1_r5.v;
			satl_s1 <= n1_sat;
			pl_s2 <= pl_s1;
			rw_s2 <= n2_rw.v;
			satl_s2 <= n2_sat;
			rs_s3 <= n3_rs;
			for (int i = 0; i < 3; i++) begin
				je_s1[i] <= n1_je[i].v;
				je_s2[i] <= je_s1[i];
				cr_s2[i] <= n2_cr[i].v;
			end
			for (int i = 0; i < 6; i++) begin
				ve_s1[i] <= n1_ve[i].v;
			end
		end
	end

	assign out_valid = vld_s3;
	assign out_rs = rs_s3;

endmodule
`default_nettype wire
